[rtl/kfd_pkg.sv]
// Package for the keyboard FIFO device.
// Holds the beat types, function codes and default constants.
// No dependencies.
package kfd_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int ENTRY_WIDTH   = 16;
    localparam logic [7:0] MASK_RESET = 8'h0F;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    localparam logic [2:0] FN_INJECT      = 3'd0;
    localparam logic [2:0] FN_READ_DATA   = 3'd1;
    localparam logic [2:0] FN_READ_STATUS = 3'd2;
    localparam logic [2:0] FN_ACK         = 3'd3;
    localparam logic [2:0] FN_OTHER_READ  = 3'd4;
    localparam logic [2:0] FN_OTHER_WRITE = 3'd5;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] key_code;
        logic [7:0] key_modifiers;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] read_data;
        logic       data_available;
        logic       overflow_flag;
        logic [7:0] front_modifiers;
        logic       key_dropped;
    } t_out_beat;

    typedef struct packed {
        logic       valid;
        logic [2:0] func;
        logic       nonempty;
        logic       ovf;
        logic       dropped;
    } t_stage;

endpackage

[rtl/kfd_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module kfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/kfd_ctrl.sv]
// Pointer, fill level, overflow and mask control for the keyboard FIFO device.
// Depends on kfd_pkg; drives the entry RAM ports and the result stage.
module kfd_ctrl #(
    parameter int BUFFER_DEPTH = kfd_pkg::DEFAULT_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  kfd_pkg::t_in_beat               i_item,
    input  logic                            i_cfg_we,
    input  logic [7:0]                      i_cfg_wdata,
    output logic                            o_wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_wr_addr,
    output logic [kfd_pkg::ENTRY_WIDTH-1:0] o_wr_data,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_rd_addr,
    output kfd_pkg::t_stage                 o_stage
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int FW = $clog2(BUFFER_DEPTH + 1);

    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FW-1:0]   r_fill, n_fill;
    logic            r_ovf, n_ovf;
    logic [7:0]      r_mask;
    kfd_pkg::t_stage r_stage, n_stage;
    logic            full;
    logic            nonempty;
    logic            push;
    logic            pop;

    assign full     = (r_fill == FW'(BUFFER_DEPTH));
    assign nonempty = (r_fill != '0);

    always_comb begin
        push     = 1'b0;
        pop      = 1'b0;
        n_ovf    = r_ovf;
        n_stage  = '0;
        n_stage.valid    = i_accept;
        n_stage.func     = i_item.func;
        n_stage.nonempty = nonempty;
        n_stage.ovf      = r_ovf;
        if (i_accept) begin
            unique case (i_item.func)
                kfd_pkg::FN_INJECT: begin
                    if (full) begin
                        n_ovf           = 1'b1;
                        n_stage.dropped = 1'b1;
                    end else begin
                        push = 1'b1;
                    end
                end
                kfd_pkg::FN_ACK: begin
                    pop   = nonempty;
                    n_ovf = 1'b0;
                end
                default: begin
                end
            endcase
        end
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(BUFFER_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            n_fill   = r_fill + FW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(BUFFER_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            n_fill   = r_fill - FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_mask   <= kfd_pkg::MASK_RESET;
            r_stage  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_fill   <= n_fill;
            r_ovf    <= n_ovf;
            r_stage  <= n_stage;
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
        end
    end

    assign o_wr_en   = push;
    assign o_wr_addr = r_wr_ptr;
    assign o_wr_data = {i_item.key_modifiers & r_mask, i_item.key_code};
    assign o_rd_addr = r_rd_ptr;
    assign o_stage   = r_stage;

endmodule

[rtl/keyboard_fifo_device.sv]
// Top level of the keyboard FIFO device.
// Depends on kfd_pkg, kfd_ctrl and kfd_ram.
//
// A command beat is taken at a rising edge with i_start high and o_busy low.
// o_busy is always low, so a new command may be issued every cycle.
// Each command gives one result beat on o_result, marked by o_result_valid
// for exactly one cycle, in the cycle right after the command is taken.
// Throughput is one command per cycle; the front entry is read from the entry
// RAM at the edge that takes the command and is available from its registered
// read port in the result cycle.
// The user writes the modifier mask with i_cfg_we and i_cfg_wdata only while
// idle; the block does not enforce this. A synchronous reset empties the buffer,
// clears the overflow flag and restores the mask to its default; the RAM contents
// are not cleared. The receiver cannot stall, so results are never held back.
module keyboard_fifo_device #(
    parameter int BUFFER_DEPTH = kfd_pkg::DEFAULT_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  kfd_pkg::t_in_beat  i_item,
    output logic               o_result_valid,
    output kfd_pkg::t_out_beat o_result,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata
);

    localparam int PW = $clog2(BUFFER_DEPTH);

    logic                            accept;
    logic                            wr_en;
    logic [PW-1:0]                   wr_addr;
    logic [kfd_pkg::ENTRY_WIDTH-1:0] wr_data;
    logic [PW-1:0]                   rd_addr;
    logic [kfd_pkg::ENTRY_WIDTH-1:0] rd_data;
    kfd_pkg::t_stage                 stage;
    logic                            show_data;
    logic                            show_status;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    kfd_ctrl #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr),
        .o_stage    (stage)
    );

    kfd_ram #(
        .WIDTH(kfd_pkg::ENTRY_WIDTH),
        .DEPTH(BUFFER_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign show_data   = (stage.func == kfd_pkg::FN_READ_DATA);
    assign show_status = (stage.func == kfd_pkg::FN_READ_STATUS);

    assign o_result_valid           = stage.valid;
    assign o_result.read_data       = (show_data && stage.nonempty) ? rd_data[7:0]
                                                                    : kfd_pkg::ZERO_BYTE;
    assign o_result.data_available  = show_status && stage.nonempty;
    assign o_result.overflow_flag   = show_status && stage.ovf;
    assign o_result.front_modifiers = (show_status && stage.nonempty) ? rd_data[15:8]
                                                                      : kfd_pkg::ZERO_BYTE;
    assign o_result.key_dropped     = (stage.func == kfd_pkg::FN_INJECT) && stage.dropped;

endmodule

[tb/keyboard_fifo_device_tb.sv]
// Self-checking testbench for the keyboard FIFO device.
// Predicts every result beat from a model of the key ring buffer and checks it.
// Depends on kfd_pkg and keyboard_fifo_device.
`timescale 1ns / 100ps

module keyboard_fifo_device_tb;
    import kfd_pkg::*;

    localparam logic [2:0] FN_SPARE_SIX   = 3'd6;
    localparam logic [2:0] FN_SPARE_SEVEN = 3'd7;
    localparam int PHASE_ITEMS   = 330;
    localparam int IDLE_LIMIT    = 500;
    localparam int MAX_REPORTS   = 10;

    class key_fifo_scoreboard;
        logic [15:0] entries [DEFAULT_DEPTH];
        int unsigned read_ptr;
        int unsigned write_ptr;
        int unsigned level;
        bit          overflow;
        logic [7:0]  mask;
        t_out_beat   expected_results [$];
        int          mismatches;

        function new();
            read_ptr   = 0;
            write_ptr  = 0;
            level      = 0;
            overflow   = 1'b0;
            mask       = MASK_RESET;
            mismatches = 0;
        endfunction

        function void set_mask(logic [7:0] value);
            mask = value;
        endfunction

        function bit is_full();
            return level == DEFAULT_DEPTH;
        endfunction

        function bit is_empty();
            return level == 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void predict_command(t_in_beat cmd);
            t_out_beat result;
            bit        nonempty;
            result   = '0;
            nonempty = level != 0;
            case (cmd.func)
                FN_INJECT: begin
                    if (level == DEFAULT_DEPTH) begin
                        overflow           = 1'b1;
                        result.key_dropped = 1'b1;
                    end else begin
                        entries[write_ptr] = {cmd.key_modifiers & mask, cmd.key_code};
                        write_ptr          = (write_ptr + 1) % DEFAULT_DEPTH;
                        level++;
                    end
                end
                FN_READ_DATA: begin
                    if (nonempty) result.read_data = entries[read_ptr][7:0];
                end
                FN_READ_STATUS: begin
                    result.data_available = nonempty;
                    result.overflow_flag  = overflow;
                    if (nonempty) result.front_modifiers = entries[read_ptr][15:8];
                end
                FN_ACK: begin
                    if (nonempty) begin
                        read_ptr = (read_ptr + 1) % DEFAULT_DEPTH;
                        level--;
                    end
                    overflow = 1'b0;
                end
                default: ;
            endcase
            expected_results.push_back(result);
        endfunction

        function void report(string field, logic [7:0] exp_val, logic [7:0] act_val);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, field,
                         exp_val, act_val);
        endfunction

        function void check_result(t_out_beat actual);
            t_out_beat exp_beat;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result beat %h with nothing expected", $time, actual);
                return;
            end
            exp_beat = expected_results.pop_front();
            if (actual.read_data !== exp_beat.read_data)
                report("read_data", exp_beat.read_data, actual.read_data);
            if (actual.data_available !== exp_beat.data_available)
                report("data_available", 8'(exp_beat.data_available),
                       8'(actual.data_available));
            if (actual.overflow_flag !== exp_beat.overflow_flag)
                report("overflow_flag", 8'(exp_beat.overflow_flag),
                       8'(actual.overflow_flag));
            if (actual.front_modifiers !== exp_beat.front_modifiers)
                report("front_modifiers", exp_beat.front_modifiers, actual.front_modifiers);
            if (actual.key_dropped !== exp_beat.key_dropped)
                report("key_dropped", 8'(exp_beat.key_dropped), 8'(actual.key_dropped));
        endfunction
    endclass

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_start        = 1'b0;
    logic       o_busy;
    t_in_beat   i_item         = '0;
    logic       o_result_valid;
    t_out_beat  o_result;
    logic       i_cfg_we       = 1'b0;
    logic [7:0] i_cfg_wdata    = '0;

    key_fifo_scoreboard key_fifo = new();
    int  items_sent = 0;
    bit  no_idle    = 1'b0;

    keyboard_fifo_device i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) key_fifo.check_result(o_result);
            if (i_start && !o_busy) key_fifo.predict_command(i_item);
            if (i_cfg_we) key_fifo.set_mask(i_cfg_wdata);
        end
    end

    function automatic t_in_beat make_beat(logic [2:0] func, logic [7:0] code,
                                           logic [7:0] mods);
        t_in_beat cmd;
        cmd.func          = func;
        cmd.key_code      = code;
        cmd.key_modifiers = mods;
        return cmd;
    endfunction

    function automatic t_in_beat random_beat(logic [2:0] func);
        return make_beat(func, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endfunction

    task automatic send_beat(t_in_beat cmd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(7);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= cmd;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (key_fifo.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_mask(logic [7:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic fill_segment();
        int extra;
        extra = $urandom_range(1, 4);
        while (!key_fifo.is_full()) begin
            if ($urandom_range(7) == 0) send_beat(random_beat(FN_READ_STATUS));
            else send_beat(random_beat(FN_INJECT));
        end
        repeat (extra) send_beat(random_beat(FN_INJECT));
        send_beat(random_beat(FN_READ_STATUS));
        if ($urandom_range(1) == 1) send_beat(random_beat(FN_ACK));
        send_beat(random_beat(FN_READ_STATUS));
    endtask

    task automatic drain_segment();
        int pick;
        int extra;
        extra = $urandom_range(1, 3);
        while (!key_fifo.is_empty()) begin
            pick = $urandom_range(3);
            case (pick)
                0:       send_beat(random_beat(FN_READ_DATA));
                1:       send_beat(random_beat(FN_READ_STATUS));
                default: send_beat(random_beat(FN_ACK));
            endcase
        end
        repeat (extra) send_beat(random_beat(FN_ACK));
        send_beat(random_beat(FN_READ_STATUS));
        send_beat(random_beat(FN_READ_DATA));
    endtask

    task automatic mixed_segment();
        int length;
        int pick;
        length = $urandom_range(10, 40);
        repeat (length) begin
            pick = $urandom_range(99);
            if (pick < 35)      send_beat(random_beat(FN_INJECT));
            else if (pick < 50) send_beat(random_beat(FN_READ_DATA));
            else if (pick < 65) send_beat(random_beat(FN_READ_STATUS));
            else if (pick < 85) send_beat(random_beat(FN_ACK));
            else                send_beat(random_beat(3'($urandom_range(4, 7))));
        end
    endtask

    task automatic random_phase(int target);
        int pick;
        while (items_sent < target) begin
            no_idle = ($urandom_range(9) < 3);
            pick    = $urandom_range(3);
            case (pick)
                0:       fill_segment();
                1:       drain_segment();
                default: mixed_segment();
            endcase
        end
        no_idle = 1'b0;
    endtask

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_start && !o_busy) || o_result_valid) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("FAIL keyboard_fifo_device");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(make_beat(FN_READ_DATA,   8'hFF, 8'hFF));
        send_beat(make_beat(FN_READ_STATUS, 8'hFF, 8'hFF));
        send_beat(make_beat(FN_ACK,         8'hFF, 8'hFF));
        send_beat(make_beat(FN_OTHER_READ,  8'hFF, 8'hFF));
        send_beat(make_beat(FN_OTHER_WRITE, 8'hFF, 8'hFF));
        send_beat(make_beat(FN_SPARE_SIX,   8'hFF, 8'hFF));
        send_beat(make_beat(FN_SPARE_SEVEN, 8'hFF, 8'hFF));
        send_beat(make_beat(FN_INJECT,      8'h00, 8'h00));
        send_beat(make_beat(FN_INJECT,      8'hFF, 8'hFF));
        send_beat(make_beat(FN_INJECT,      8'h5A, 8'hA5));
        send_beat(make_beat(FN_READ_STATUS, 8'h00, 8'h00));
        send_beat(make_beat(FN_READ_DATA,   8'h00, 8'h00));
        send_beat(make_beat(FN_OTHER_READ,  8'h00, 8'h00));
        send_beat(make_beat(FN_ACK,         8'h00, 8'h00));
        send_beat(make_beat(FN_READ_STATUS, 8'h00, 8'h00));
        send_beat(make_beat(FN_READ_DATA,   8'h00, 8'h00));
        send_beat(make_beat(FN_ACK,         8'h00, 8'h00));
        send_beat(make_beat(FN_READ_DATA,   8'h00, 8'h00));
        send_beat(make_beat(FN_READ_STATUS, 8'h00, 8'h00));
        send_beat(make_beat(FN_ACK,         8'h00, 8'h00));
        send_beat(make_beat(FN_READ_STATUS, 8'h00, 8'h00));

        write_mask(8'hFF);
        random_phase(items_sent + PHASE_ITEMS);
        write_mask(8'h00);
        random_phase(items_sent + PHASE_ITEMS);
        write_mask(8'($urandom_range(255)));
        random_phase(items_sent + PHASE_ITEMS);
        write_mask(8'($urandom_range(255)));
        random_phase(items_sent + PHASE_ITEMS);
        write_mask(MASK_RESET);
        random_phase(items_sent + PHASE_ITEMS);

        wait_drained();
        repeat (2) @(posedge i_clk);
        if (key_fifo.mismatches == 0 && key_fifo.pending() == 0) begin
            $display("PASS keyboard_fifo_device");
        end else begin
            $display("FAIL keyboard_fifo_device");
        end
        $finish;
    end

endmodule
